@@ rtl/core/lrts_pkg.sv @@
// Package for the longest-remaining-time scheduler core.
// Field widths, slot entry layout, sequencer states and shared pick status.
// No dependencies.
`default_nettype none

package lrts_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  localparam int unsigned SLOT_W = 3;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned BURST_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // op field codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one slot of the job table as stored in RAM
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // tick sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_REPORT
  } state_e;

  // running result of the slot scan
  typedef struct packed {
    logic   found;   // some eligible slot seen
    logic   any_nz;  // at least one slot with work left
    logic   two_nz;  // at least two slots with work left
    entry_t best;    // entry of the current winner
  } pick_t;

endpackage

`default_nettype wire

@@ rtl/core/lrts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module lrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/lrts_pick.sv @@
// Scan unit: takes one slot entry per cycle while en_i is high and keeps the
// eligible slot with most work left (earliest on ties) plus work-left flags.
// Depends on lrts_pkg.
`default_nettype none

module lrts_pick #(
  parameter int unsigned SLOTS = lrts_pkg::SLOTS_DEF,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clr_i,
  input  wire logic                         en_i,
  input  wire logic [IW-1:0]                idx_i,
  input  wire lrts_pkg::entry_t             entry_i,
  input  wire logic [lrts_pkg::TIME_W-1:0]  now_i,
  output lrts_pkg::pick_t                   pick_o,
  output logic      [IW-1:0]                best_idx_o
);

  lrts_pkg::pick_t pick_q, pick_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            nz;
  logic            elig;
  logic            take;

  // compare the incoming entry against the current winner
  always_comb begin
    nz     = (entry_i.remaining != '0);
    elig   = nz && (entry_i.arrival <= now_i);
    take   = elig && (!pick_q.found || (entry_i.remaining > pick_q.best.remaining));
    pick_d = pick_q;
    idx_d  = idx_q;
    if (clr_i) begin
      pick_d.found  = 1'b0;
      pick_d.any_nz = 1'b0;
      pick_d.two_nz = 1'b0;
    end else if (en_i) begin
      if (take) begin
        pick_d.found = 1'b1;
        pick_d.best  = entry_i;
        idx_d        = idx_i;
      end
      if (nz) begin
        pick_d.any_nz = 1'b1;
        pick_d.two_nz = pick_q.any_nz;
      end
    end
  end

  // running pick and winner index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
      idx_q  <= '0;
    end else begin
      pick_q <= pick_d;
      idx_q  <= idx_d;
    end
  end

  assign pick_o     = pick_q;
  assign best_idx_o = idx_q;

endmodule

`default_nettype wire

@@ rtl/core/longest_remaining_time_scheduler_core.sv @@
// Top level of the longest-remaining-time-first scheduler.
// Depends on lrts_pkg, lrts_ram and lrts_pick.
//
//  channel  | handshake              | words
//  ---------+------------------------+---------------------------------------
//  command  | start_i, busy_o        | op, slot, job_id, arrival, burst
//  result   | done_o (1-cycle pulse) | idle ... all_done, one per tick
//
// A load word is written to the slot RAM in the cycle it is accepted; busy_o
// stays low, so loads can follow back to back. A tick word runs SCAN, DRAIN,
// UPDATE and REPORT: one RAM read per slot through the single read port, a
// drain state for the read latency, write-back and report; done_o pulses
// in the cycle after that. Reset clears the clock and the per-slot valid
// flags; a slot never loaded reads as all zero. Results cannot be stalled.
`default_nettype none

module longest_remaining_time_scheduler_core #(
  parameter int unsigned SLOTS = lrts_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          op_i,
  input  wire logic [lrts_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [lrts_pkg::ID_W-1:0]     job_id_i,
  input  wire logic [lrts_pkg::TIME_W-1:0]   arrival_i,
  input  wire logic [lrts_pkg::BURST_W-1:0]  burst_i,
  output logic                               done_o,
  output logic                               idle_o,
  output logic      [lrts_pkg::SLOT_W-1:0]   chosen_slot_o,
  output logic      [lrts_pkg::ID_W-1:0]     chosen_id_o,
  output logic      [lrts_pkg::TIME_W-1:0]   tick_time_o,
  output logic                               completed_o,
  output logic      [lrts_pkg::TIME_W-1:0]   completion_time_o,
  output logic      [lrts_pkg::TIME_W-1:0]   turnaround_o,
  output logic      [lrts_pkg::TIME_W-1:0]   waiting_o,
  output logic                               all_done_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  lrts_pkg::state_e state_q, state_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [lrts_pkg::TIME_W-1:0] clk_time_q, clk_time_d;
  logic [lrts_pkg::TIME_W-1:0] ct;
  logic [SLOTS-1:0] valid_q;

  logic             accept;
  logic             load_go;
  logic             tick_go;
  logic             load_in_range;

  // RAM ports
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  lrts_pkg::entry_t            ram_wdata;
  lrts_pkg::entry_t            ram_rdata;
  logic [lrts_pkg::ENTRY_W-1:0] ram_rdata_raw;

  // compare stage, registered alongside the RAM read data
  logic             cmp_en_q;
  logic [IW-1:0]    cmp_idx_q;
  logic             rd_valid_q;
  lrts_pkg::entry_t cmp_entry;

  lrts_pkg::pick_t  pick;
  logic [IW-1:0]    best_idx;

  // update stage results
  logic                        cmpl_q;
  logic                        all_done_q;
  logic [lrts_pkg::TIME_W-1:0] ct_q;
  logic [lrts_pkg::TIME_W-1:0] tat_q;
  logic [lrts_pkg::BURST_W-1:0] new_rem;

  assign accept        = start_i && !busy_o;
  assign load_in_range = (32'(slot_i) < SLOTS);
  assign load_go       = accept && (op_i == lrts_pkg::OP_LOAD) && load_in_range;
  assign tick_go       = accept && (op_i == lrts_pkg::OP_TICK);
  assign busy_o        = (state_q != lrts_pkg::ST_IDLE);

  // saturating next clock value, also the completion time
  assign ct = (clk_time_q == lrts_pkg::TIME_MAX) ? clk_time_q : clk_time_q + 1'b1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clk_time_d = clk_time_q;
    case (state_q)
      lrts_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (tick_go) begin
          state_d = lrts_pkg::ST_SCAN;
        end
      end
      lrts_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(SLOTS - 1)) begin
          state_d = lrts_pkg::ST_DRAIN;
        end
      end
      lrts_pkg::ST_DRAIN: begin
        state_d = lrts_pkg::ST_UPDATE;
      end
      lrts_pkg::ST_UPDATE: begin
        state_d = lrts_pkg::ST_REPORT;
      end
      lrts_pkg::ST_REPORT: begin
        clk_time_d = ct;
        state_d    = lrts_pkg::ST_IDLE;
      end
      default: begin
        state_d = lrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lrts_pkg::ST_IDLE;
      cnt_q      <= '0;
      clk_time_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clk_time_q <= clk_time_d;
    end
  end

  // per-slot valid flags: a slot never loaded reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_go) begin
      valid_q[IW'(slot_i)] <= 1'b1;
    end
  end

  // write port: loads in idle, the winner's write-back in update
  always_comb begin
    new_rem   = pick.best.remaining - 1'b1;
    ram_we    = 1'b0;
    ram_waddr = IW'(slot_i);
    ram_wdata.id        = job_id_i;
    ram_wdata.arrival   = arrival_i;
    ram_wdata.remaining = burst_i;
    ram_wdata.burst     = burst_i;
    if (load_go) begin
      ram_we = 1'b1;
    end else if ((state_q == lrts_pkg::ST_UPDATE) && pick.found) begin
      ram_we              = 1'b1;
      ram_waddr           = best_idx;
      ram_wdata           = pick.best;
      ram_wdata.remaining = new_rem;
    end
  end

  lrts_ram #(
    .WIDTH (lrts_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = lrts_pkg::entry_t'(ram_rdata_raw);

  // align the read data with its slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= (state_q == lrts_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cnt_q;
    rd_valid_q <= valid_q[cnt_q];
  end

  assign cmp_entry = rd_valid_q ? ram_rdata : '0;

  lrts_pick #(
    .SLOTS (SLOTS)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (tick_go),
    .en_i       (cmp_en_q),
    .idx_i      (cmp_idx_q),
    .entry_i    (cmp_entry),
    .now_i      (clk_time_q),
    .pick_o     (pick),
    .best_idx_o (best_idx)
  );

  // update stage: completion, turnaround and the all-done check
  always_ff @(posedge clk_i) begin
    if (state_q == lrts_pkg::ST_UPDATE) begin
      cmpl_q     <= pick.found && (new_rem == '0);
      all_done_q <= !pick.any_nz ||
                    (pick.found && !pick.two_nz && (pick.best.remaining == 16'd1));
      ct_q       <= ct;
      tat_q      <= (ct >= pick.best.arrival) ? ct - pick.best.arrival : '0;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == lrts_pkg::ST_REPORT);
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (state_q == lrts_pkg::ST_REPORT) begin
      idle_o            <= !pick.found;
      chosen_slot_o     <= pick.found ? lrts_pkg::SLOT_W'(best_idx) : '0;
      chosen_id_o       <= pick.found ? pick.best.id : '0;
      tick_time_o       <= clk_time_q;
      completed_o       <= cmpl_q;
      completion_time_o <= cmpl_q ? ct_q : '0;
      turnaround_o      <= cmpl_q ? tat_q : '0;
      waiting_o         <= (cmpl_q && (tat_q >= 32'(pick.best.burst))) ?
                           tat_q - 32'(pick.best.burst) : '0;
      all_done_o        <= all_done_q;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == lrts_pkg::ST_IDLE))
    else $error("result strobe while a tick is still in flight");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> busy_o)
    else $error("accepted tick did not raise busy");

  a_cmpl_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && completed_o) |-> !idle_o)
    else $error("completion reported on an idle tick");

  a_cmpl_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && completed_o) |->
      ((completion_time_o == tick_time_o + 32'd1) ||
       (completion_time_o == lrts_pkg::TIME_MAX)))
    else $error("completion time does not follow tick time");

endmodule

`default_nettype wire

@@ bench/longest_remaining_time_scheduler_core_tb.sv @@
// Self-checking bench for longest_remaining_time_scheduler_core: load and tick words,
// a local LRTF scheduler predictor and an in-order result check.
// Depends on lrts_pkg and the scheduler core RTL.
`default_nettype none

module longest_remaining_time_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = lrts_pkg::SLOTS_DEF;
  localparam int unsigned SLOT_W      = lrts_pkg::SLOT_W;
  localparam int unsigned ID_W        = lrts_pkg::ID_W;
  localparam int unsigned TIME_W      = lrts_pkg::TIME_W;
  localparam int unsigned BURST_W     = lrts_pkg::BURST_W;
  localparam int unsigned N_RANDOM    = 800;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // one command word as queued for the driver
  typedef struct {
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } sched_word_t;

  // one tick report
  typedef struct packed {
    logic               idle;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  tick_time;
    logic               completed;
    logic [TIME_W-1:0]  completion_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic               all_done;
  } tick_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               op_i;
  logic [SLOT_W-1:0]  slot_i;
  logic [ID_W-1:0]    job_id_i;
  logic [TIME_W-1:0]  arrival_i;
  logic [BURST_W-1:0] burst_i;
  logic               done_o;
  logic               idle_o;
  logic [SLOT_W-1:0]  chosen_slot_o;
  logic [ID_W-1:0]    chosen_id_o;
  logic [TIME_W-1:0]  tick_time_o;
  logic               completed_o;
  logic [TIME_W-1:0]  completion_time_o;
  logic [TIME_W-1:0]  turnaround_o;
  logic [TIME_W-1:0]  waiting_o;
  logic               all_done_o;

  longest_remaining_time_scheduler_core #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .job_id_i         (job_id_i),
    .arrival_i        (arrival_i),
    .burst_i          (burst_i),
    .done_o           (done_o),
    .idle_o           (idle_o),
    .chosen_slot_o    (chosen_slot_o),
    .chosen_id_o      (chosen_id_o),
    .tick_time_o      (tick_time_o),
    .completed_o      (completed_o),
    .completion_time_o(completion_time_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o),
    .all_done_o       (all_done_o)
  );

  sched_word_t  word_q[$];
  tick_report_t report_q[$];

  // predictor copy of the job table and clock
  logic [ID_W-1:0]    job_id_tbl  [SLOTS];
  logic [TIME_W-1:0]  arrival_tbl [SLOTS];
  logic [BURST_W-1:0] left_tbl    [SLOTS];
  logic [BURST_W-1:0] burst_tbl   [SLOTS];
  logic [TIME_W-1:0]  sched_clock;

  logic        word_taken;
  int unsigned gap_left;
  int unsigned words_sent;
  int unsigned cycle_cnt;
  int unsigned errors;
  logic [TIME_W-1:0] gen_clock;  // clock value the next queued tick will see

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // queue a word; ticks advance the generator's view of the clock
  function automatic void add_word(logic op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] arrival, logic [BURST_W-1:0] burst);
    sched_word_t w;
    w.op = op;
    w.slot = slot;
    w.id = id;
    w.arrival = arrival;
    w.burst = burst;
    word_q.push_back(w);
    if (op == lrts_pkg::OP_TICK) gen_clock++;
  endfunction

  // arrival close to the clock the word will meet, so the job soon becomes eligible
  function automatic logic [TIME_W-1:0] near_arrival();
    logic [TIME_W-1:0] base;
    base = (gen_clock > 3) ? gen_clock - 3 : '0;
    return base + TIME_W'($urandom_range(0, 8));
  endfunction

  // serve one time unit: pick the eligible slot with the most work left, lowest index on tie
  function automatic void serve_tick();
    int best;
    tick_report_t r;
    logic [TIME_W-1:0] fin;
    logic [TIME_W-1:0] tat;
    best = -1;
    for (int k = 0; k < SLOTS; k++) begin
      if (left_tbl[k] != 0 && arrival_tbl[k] <= sched_clock) begin
        if (best < 0 || left_tbl[k] > left_tbl[best]) best = k;
      end
    end
    r = '0;
    r.tick_time = sched_clock;
    if (best < 0) begin
      r.idle = 1'b1;
    end else begin
      r.slot = SLOT_W'(best);
      r.id = job_id_tbl[best];
      left_tbl[best] = left_tbl[best] - 1'b1;
      if (left_tbl[best] == 0) begin
        fin = (sched_clock == lrts_pkg::TIME_MAX) ? sched_clock : sched_clock + 1'b1;
        tat = (fin >= arrival_tbl[best]) ? fin - arrival_tbl[best] : '0;
        r.completed = 1'b1;
        r.completion_time = fin;
        r.turnaround = tat;
        r.waiting = (tat >= TIME_W'(burst_tbl[best])) ? tat - TIME_W'(burst_tbl[best]) : '0;
      end
    end
    if (sched_clock != lrts_pkg::TIME_MAX) sched_clock++;
    r.all_done = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (left_tbl[k] != 0) r.all_done = 1'b0;
    end
    report_q.push_back(r);
  endfunction

  task automatic cmp_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver: a new word goes out after the previous one is taken and its gap has run out
  always @(negedge clk_i) begin
    sched_word_t w;
    if (rst_ni && (!start_i || word_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        op_i <= w.op;
        slot_i <= w.slot;
        job_id_i <= w.id;
        arrival_i <= w.arrival;
        burst_i <= w.burst;
        start_i <= 1'b1;
        // every third stretch of 40 words runs back to back
        gap_left <= ((words_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
        words_sent <= words_sent + 1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check reports against the oldest prediction, then feed accepted words
  always @(posedge clk_i) begin
    tick_report_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %h id %h",
                   $time, chosen_slot_o, chosen_id_o);
          errors++;
        end else begin
          want = report_q.pop_front();
          cmp_field("idle", TIME_W'(want.idle), TIME_W'(idle_o));
          cmp_field("chosen_slot", TIME_W'(want.slot), TIME_W'(chosen_slot_o));
          cmp_field("chosen_id", TIME_W'(want.id), TIME_W'(chosen_id_o));
          cmp_field("tick_time", want.tick_time, tick_time_o);
          cmp_field("completed", TIME_W'(want.completed), TIME_W'(completed_o));
          cmp_field("completion_time", want.completion_time, completion_time_o);
          cmp_field("turnaround", want.turnaround, turnaround_o);
          cmp_field("waiting", want.waiting, waiting_o);
          cmp_field("all_done", TIME_W'(want.all_done), TIME_W'(all_done_o));
        end
      end
      if (start_i && !busy_o) begin
        if (op_i == lrts_pkg::OP_TICK) begin
          serve_tick();
        end else if (int'(slot_i) < SLOTS) begin
          job_id_tbl[slot_i] = job_id_i;
          arrival_tbl[slot_i] = arrival_i;
          left_tbl[slot_i] = burst_i;
          burst_tbl[slot_i] = burst_i;
        end
      end
    end
    word_taken <= rst_ni && start_i && !busy_o;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned n_loads;
    int unsigned n_ticks;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = lrts_pkg::OP_LOAD;
    slot_i = '0;
    job_id_i = '0;
    arrival_i = '0;
    burst_i = '0;
    word_taken = 1'b0;
    gap_left = 0;
    words_sent = 0;
    cycle_cnt = 0;
    errors = 0;
    gen_clock = '0;
    sched_clock = '0;
    for (int k = 0; k < SLOTS; k++) begin
      job_id_tbl[k] = '0;
      arrival_tbl[k] = '0;
      left_tbl[k] = '0;
      burst_tbl[k] = '0;
    end

    // directed: idle tick on an empty table
    add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
    // job that never arrives keeps all_done low while idle
    add_word(lrts_pkg::OP_LOAD, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
    // one-unit job completes at once, slot 0 with id zero
    add_word(lrts_pkg::OP_LOAD, 3'd0, 16'h0000, 32'h0, 16'd1);
    add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
    // reload with zero burst empties the slot
    add_word(lrts_pkg::OP_LOAD, 3'd7, 16'h1234, 32'h0, 16'd0);
    // tie between slots 2 and 5: lower slot first, then alternation
    add_word(lrts_pkg::OP_LOAD, 3'd2, 16'hAAAA, 32'h0, 16'd2);
    add_word(lrts_pkg::OP_LOAD, 3'd5, 16'h5555, 32'h0, 16'd2);
    repeat (4) add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
    // later arrival: the shorter job that is present runs first, then an idle gap
    add_word(lrts_pkg::OP_LOAD, 3'd3, 16'h0F0F, gen_clock + 2, 16'd2);
    add_word(lrts_pkg::OP_LOAD, 3'd4, 16'hF0F0, 32'h0, 16'd1);
    repeat (2) add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
    // reload of a slot in progress restarts its work
    add_word(lrts_pkg::OP_LOAD, 3'd3, 16'h3C3C, gen_clock, 16'd3);
    repeat (4) add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);

    // random: mostly load batches followed by ticks, some raw noise
    while (word_q.size() < N_RANDOM + 20) begin
      if ($urandom_range(0, 4) != 0) begin
        n_loads = $urandom_range(1, 3);
        n_ticks = $urandom_range(1, 10);
        repeat (n_loads) begin
          add_word(lrts_pkg::OP_LOAD, SLOT_W'($urandom_range(0, SLOTS - 1)),
                   ID_W'($urandom), near_arrival(),
                   ($urandom_range(0, 30) == 0) ? BURST_W'($urandom) :
                                                  BURST_W'($urandom_range(0, 12)));
        end
        repeat (n_ticks) add_word(lrts_pkg::OP_TICK, '0, '0, '0, '0);
      end else begin
        add_word(1'($urandom), SLOT_W'($urandom), ID_W'($urandom), TIME_W'($urandom),
                 BURST_W'($urandom));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_q.size() != 0 || start_i) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/lrts_pkg.sv
rtl/core/lrts_ram.sv
rtl/core/lrts_pick.sv
rtl/core/longest_remaining_time_scheduler_core.sv
bench/longest_remaining_time_scheduler_core_tb.sv
